@@ rtl/core/lens_distortion_remap_assert.svh @@
// ----------------------------------------------------------------------------
// Lens distortion remap assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LENS_DISTORTION_REMAP_ASSERT_SVH
`define LENS_DISTORTION_REMAP_ASSERT_SVH

// same-cycle implication
`define LDR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ldr_pkg.sv @@
// ----------------------------------------------------------------------------
// Lens distortion remap package
// Field widths, register codes, beat and configuration types, saturation.
// ----------------------------------------------------------------------------
package ldr_pkg;

  localparam int COORD_BITS = 12;
  localparam int SIZE_W     = 13;
  localparam int COEF_W     = 32;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;

  localparam logic [SIZE_W-1:0]        WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0]        HEIGHT_RST = 13'd480;
  localparam logic signed [COEF_W-1:0] K3_RST     = -32'sd31052447;
  localparam logic signed [COEF_W-1:0] Q_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] Q_MIN      = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_K1     = 3'd2,
    REG_K2     = 3'd3,
    REG_K3     = 3'd4,
    REG_P1     = 3'd5,
    REG_P2     = 3'd6
  } ldr_reg_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] src_col;
    logic [COORD_BITS-1:0] src_row;
    logic [PIX_W-1:0]      pixel_value;
  } ldr_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] dst_col;
    logic [COORD_BITS-1:0] dst_row;
    logic [PIX_W-1:0]      pixel_out;
    logic                  inside_res;
  } ldr_out_t;

  typedef struct packed {
    logic [SIZE_W-1:0]        image_width;
    logic [SIZE_W-1:0]        image_height;
    logic signed [COEF_W-1:0] radial_k1;
    logic signed [COEF_W-1:0] radial_k2;
    logic signed [COEF_W-1:0] radial_k3;
    logic signed [COEF_W-1:0] tangential_p1;
    logic signed [COEF_W-1:0] tangential_p2;
  } ldr_cfg_t;

  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [COEF_W-1:0] r;
    if (v > 64'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < 64'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/lens_distortion_remap.sv @@
// ----------------------------------------------------------------------------
// Lens distortion remap
// Brown-Conrady distortion of one source pixel per beat, fixed point.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | ldr_in_t  (col, row, pixel)
//  out     | output    | out_valid_o / out_stall_i | ldr_out_t (col, row, pixel, inside)
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One beat per cycle while the output is not stalled; each beat passes through the
//  bit-per-stage dividers for x and y, then the polynomial, then the projection.
//  Reset clears valid bits and loads the default registers.
//  A stalled output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "lens_distortion_remap_assert.svh"

module lens_distortion_remap
  import ldr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ldr_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ldr_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  ldr_cfg_t           cfg_q;
  logic               en;
  logic               nv, pv;
  logic [PIX_W-1:0]   npix, ppix;
  logic signed [31:0] nx, ny;
  logic signed [35:0] xb, yb;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= WIDTH_RST;
      cfg_q.image_height  <= HEIGHT_RST;
      cfg_q.radial_k1     <= '0;
      cfg_q.radial_k2     <= '0;
      cfg_q.radial_k3     <= K3_RST;
      cfg_q.tangential_p1 <= '0;
      cfg_q.tangential_p2 <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WIDTH:  cfg_q.image_width   <= cfg_data_i[SIZE_W-1:0];
        REG_HEIGHT: cfg_q.image_height  <= cfg_data_i[SIZE_W-1:0];
        REG_K1:     cfg_q.radial_k1     <= $signed(cfg_data_i);
        REG_K2:     cfg_q.radial_k2     <= $signed(cfg_data_i);
        REG_K3:     cfg_q.radial_k3     <= $signed(cfg_data_i);
        REG_P1:     cfg_q.tangential_p1 <= $signed(cfg_data_i);
        REG_P2:     cfg_q.tangential_p2 <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  ldr_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (nv),
    .pix_o   (npix),
    .x_o     (nx),
    .y_o     (ny)
  );

  ldr_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nv),
    .pix_i   (npix),
    .x_i     (nx),
    .y_i     (ny),
    .cfg_i   (cfg_q),
    .valid_o (pv),
    .pix_o   (ppix),
    .xb_o    (xb),
    .yb_o    (yb)
  );

  ldr_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pv),
    .pix_i   (ppix),
    .xb_i    (xb),
    .yb_i    (yb),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  `LDR_ASSERT_IMP(a_stall_only_full, in_stall_o, out_valid_o, "input stalled with empty output")
  `LDR_ASSERT_IMP(a_outside_zero, out_valid_o && !out_data_o.inside_res, (out_data_o.dst_col == '0) && (out_data_o.dst_row == '0), "outside target with nonzero coordinates")
  `LDR_ASSERT_IMP(a_inside_bound, out_valid_o && out_data_o.inside_res, (13'(out_data_o.dst_col) < cfg_q.image_width) && (13'(out_data_o.dst_row) < cfg_q.image_height), "inside target beyond image")

endmodule

@@ rtl/core/ldr_norm.sv @@
// ----------------------------------------------------------------------------
// Lens distortion remap coordinate normalizer
// Pipelined restoring dividers giving x and y in signed Q2.30, one bit a stage.
// ----------------------------------------------------------------------------
module ldr_norm
  import ldr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  ldr_in_t                  data_i,
  input  ldr_cfg_t                 cfg_i,
  output logic                     valid_o,
  output logic [PIX_W-1:0]         pix_o,
  output logic signed [COEF_W-1:0] x_o,
  output logic signed [COEF_W-1:0] y_o
);

  localparam int DB    = COORD_BITS + 1;
  localparam int QB    = DB + 30;
  localparam int DEPTH = QB + 2;

  typedef struct packed {
    logic [QB-1:0]     num;
    logic [SIZE_W-1:0] rem;
    logic [QB-1:0]     quo;
    logic              neg;
  } dv_t;

  function automatic dv_t div_step(input dv_t a, input logic [SIZE_W-1:0] d);
    logic [SIZE_W:0] t;
    dv_t             r;
    r     = a;
    t     = {a.rem, a.num[QB-1]};
    r.num = a.num << 1;
    if (t >= {1'b0, d}) begin
      t     = t - {1'b0, d};
      r.quo = {a.quo[QB-2:0], 1'b1};
    end else begin
      r.quo = {a.quo[QB-2:0], 1'b0};
    end
    r.rem = t[SIZE_W-1:0];
    return r;
  endfunction

  function automatic dv_t div_entry(input logic [COORD_BITS-1:0] pos,
                                    input logic [SIZE_W-1:0] size);
    logic signed [DB:0] d;
    logic [DB-1:0]      mag;
    dv_t                r;
    d     = $signed({2'b00, pos}) - $signed({2'b00, size[SIZE_W-1:1]});
    mag   = d[DB] ? DB'(-d) : d[DB-1:0];
    r.num = {mag, 30'd0};
    r.rem = '0;
    r.quo = '0;
    r.neg = d[DB];
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] div_sat(input dv_t a);
    logic signed [63:0] v;
    v = $signed({{(64-QB){1'b0}}, a.quo});
    if (a.neg) begin
      v = -v;
    end
    return sat32(v);
  endfunction

  logic [DEPTH-1:0] v_q;
  logic [PIX_W-1:0] pix_q [DEPTH];
  dv_t              xs_q  [QB+1];
  dv_t              ys_q  [QB+1];
  logic signed [COEF_W-1:0] x_q, y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DEPTH-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q[0] <= data_i.pixel_value;
      for (int s = 1; s < DEPTH; s++) begin
        pix_q[s] <= pix_q[s-1];
      end
      xs_q[0] <= div_entry(data_i.src_col, cfg_i.image_width);
      ys_q[0] <= div_entry(data_i.src_row, cfg_i.image_height);
      for (int s = 1; s <= QB; s++) begin
        xs_q[s] <= div_step(xs_q[s-1], cfg_i.image_width);
        ys_q[s] <= div_step(ys_q[s-1], cfg_i.image_height);
      end
      x_q <= div_sat(xs_q[QB]);
      y_q <= div_sat(ys_q[QB]);
    end
  end

  assign valid_o = v_q[DEPTH-1];
  assign pix_o   = pix_q[DEPTH-1];
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

@@ rtl/core/ldr_poly.sv @@
// ----------------------------------------------------------------------------
// Lens distortion remap polynomial
// Radial and tangential terms, giving distorted normalized coordinates.
// ----------------------------------------------------------------------------
module ldr_poly
  import ldr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [PIX_W-1:0]         pix_i,
  input  logic signed [COEF_W-1:0] x_i,
  input  logic signed [COEF_W-1:0] y_i,
  input  ldr_cfg_t                 cfg_i,
  output logic                     valid_o,
  output logic [PIX_W-1:0]         pix_o,
  output logic signed [35:0]       xb_o,
  output logic signed [35:0]       yb_o
);

  localparam int STAGES = 10;

  logic [STAGES-1:0] v_q;
  logic [PIX_W-1:0]  pix_q [STAGES];

  logic signed [31:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  logic signed [31:0] x5_q, y5_q, x6_q, y6_q, x7_q, y7_q, x8_q, y8_q;
  logic signed [63:0] xx1_q, yy1_q, xyp1_q;
  logic signed [31:0] sqx2_q, sqy2_q, xy2_q, r22_q;
  logic signed [31:0] xy3_q, r23_q, tx3_q, ty3_q;
  logic signed [63:0] r4p3_q, k1p3_q;
  logic signed [31:0] xy4_q, r24_q, r44_q, tx4_q, ty4_q;
  logic signed [63:0] k1p4_q;
  logic signed [63:0] r6p5_q, k1p5_q, k2p5_q, p1xy5_q, p2tx5_q, p1ty5_q, p2xy5_q;
  logic signed [31:0] r66_q, dx6_q, dy6_q;
  logic signed [35:0] mk16_q, mk26_q, mk17_q, mk27_q;
  logic signed [63:0] k3p7_q;
  logic signed [31:0] dx7_q, dy7_q, scale8_q, dx8_q, dy8_q, dx9_q, dy9_q;
  logic signed [63:0] xs9_q, ys9_q;
  logic signed [35:0] xb10_q, yb10_q;
  logic [63:0]        sq_sum;

  assign sq_sum = $unsigned(xx1_q) + $unsigned(yy1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q[0] <= pix_i;
      for (int s = 1; s < STAGES; s++) begin
        pix_q[s] <= pix_q[s-1];
      end
      x1_q   <= x_i;
      y1_q   <= y_i;
      xx1_q  <= x_i * x_i;
      yy1_q  <= y_i * y_i;
      xyp1_q <= x_i * y_i;

      x2_q   <= x1_q;
      y2_q   <= y1_q;
      sqx2_q <= $signed({1'b0, xx1_q[62:32]});
      sqy2_q <= $signed({1'b0, yy1_q[62:32]});
      xy2_q  <= 32'(xyp1_q >>> 32);
      r22_q  <= sq_sum[63] ? Q_MAX : $signed({1'b0, sq_sum[62:32]});

      x3_q   <= x2_q;
      y3_q   <= y2_q;
      xy3_q  <= xy2_q;
      r23_q  <= r22_q;
      r4p3_q <= r22_q * r22_q;
      k1p3_q <= cfg_i.radial_k1 * r22_q;
      tx3_q  <= sat32(64'(r22_q) + (64'(sqx2_q) <<< 1));
      ty3_q  <= sat32(64'(r22_q) + (64'(sqy2_q) <<< 1));

      x4_q   <= x3_q;
      y4_q   <= y3_q;
      xy4_q  <= xy3_q;
      r24_q  <= r23_q;
      r44_q  <= sat32(r4p3_q >>> 28);
      k1p4_q <= k1p3_q;
      tx4_q  <= tx3_q;
      ty4_q  <= ty3_q;

      x5_q    <= x4_q;
      y5_q    <= y4_q;
      r6p5_q  <= r44_q * r24_q;
      k1p5_q  <= k1p4_q;
      k2p5_q  <= cfg_i.radial_k2 * r44_q;
      p1xy5_q <= cfg_i.tangential_p1 * xy4_q;
      p2tx5_q <= cfg_i.tangential_p2 * tx4_q;
      p1ty5_q <= cfg_i.tangential_p1 * ty4_q;
      p2xy5_q <= cfg_i.tangential_p2 * xy4_q;

      x6_q   <= x5_q;
      y6_q   <= y5_q;
      r66_q  <= sat32(r6p5_q >>> 28);
      mk16_q <= 36'(k1p5_q >>> 28);
      mk26_q <= 36'(k2p5_q >>> 28);
      dx6_q  <= sat32(((p1xy5_q >>> 28) <<< 1) + (p2tx5_q >>> 28));
      dy6_q  <= sat32((p1ty5_q >>> 28) + ((p2xy5_q >>> 28) <<< 1));

      x7_q   <= x6_q;
      y7_q   <= y6_q;
      k3p7_q <= cfg_i.radial_k3 * r66_q;
      mk17_q <= mk16_q;
      mk27_q <= mk26_q;
      dx7_q  <= dx6_q;
      dy7_q  <= dy6_q;

      x8_q     <= x7_q;
      y8_q     <= y7_q;
      scale8_q <= sat32((64'sd1 <<< 28) + 64'(mk17_q) + 64'(mk27_q) + (k3p7_q >>> 28));
      dx8_q    <= dx7_q;
      dy8_q    <= dy7_q;

      xs9_q <= x8_q * scale8_q;
      ys9_q <= y8_q * scale8_q;
      dx9_q <= dx8_q;
      dy9_q <= dy8_q;

      xb10_q <= 36'(xs9_q >>> 30) + 36'(dx9_q);
      yb10_q <= 36'(ys9_q >>> 30) + 36'(dy9_q);
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign pix_o   = pix_q[STAGES-1];
  assign xb_o    = xb10_q;
  assign yb_o    = yb10_q;

endmodule

@@ rtl/core/ldr_proj.sv @@
// ----------------------------------------------------------------------------
// Lens distortion remap projection
// Back to pixel space, bounds check and output register.
// ----------------------------------------------------------------------------
module ldr_proj
  import ldr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [PIX_W-1:0]   pix_i,
  input  logic signed [35:0] xb_i,
  input  logic signed [35:0] yb_i,
  input  ldr_cfg_t           cfg_i,
  output logic               valid_o,
  output ldr_out_t           data_o
);

  logic                 va_q, vb_q;
  logic [PIX_W-1:0]     pixa_q;
  logic signed [51:0]   xa_q, ya_q;
  logic                 in_img;
  ldr_out_t             out_d, out_q;

  always_comb begin
    in_img = !xa_q[51] && !ya_q[51]
             && (xa_q[51:28] < 24'(cfg_i.image_width))
             && (ya_q[51:28] < 24'(cfg_i.image_height))
             && (cfg_i.image_width != '0) && (cfg_i.image_height != '0);
    out_d.pixel_out  = pixa_q;
    out_d.inside_res = in_img;
    out_d.dst_col    = in_img ? xa_q[28+COORD_BITS-1:28] : '0;
    out_d.dst_row    = in_img ? ya_q[28+COORD_BITS-1:28] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pixa_q <= pix_i;
      xa_q   <= 52'(xb_i) * 52'($signed({1'b0, cfg_i.image_width}))
                + $signed({12'd0, cfg_i.image_width[SIZE_W-1:1], 28'd0});
      ya_q   <= 52'(yb_i) * 52'($signed({1'b0, cfg_i.image_height}))
                + $signed({12'd0, cfg_i.image_height[SIZE_W-1:1], 28'd0});
      out_q  <= out_d;
    end
  end

  assign valid_o = vb_q;
  assign data_o  = out_q;

endmodule
